/* sv/rfjd_pkg.sv */
// ----------------------------------------------------------------------------
// rfjd_pkg: shared types and constants of the RF jamming detector
// Register indexes, request and detection codes, reset values and the
// configuration struct that travels from the register file to the datapaths.
// ----------------------------------------------------------------------------
package rfjd_pkg;

    // default parameter values
    localparam int RSSI_DEPTH_DEF = 10;
    localparam int COUNT_BITS_DEF = 12;

    // configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_WINDOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_WINDOW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_NEEDED      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RSSI_VALID_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RSSI_VALID_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_JAM_LEVEL = 3'd6;

    // register reset values
    localparam logic [6:0]  DUTY_THRESHOLD_RST  = 7'd50;
    localparam logic [11:0] SHORT_WINDOW_RST    = 12'd500;
    localparam logic [11:0] LONG_WINDOW_RST     = 12'd3750;
    localparam logic [6:0]  RUN_NEEDED_RST      = 7'd16;
    localparam logic [7:0]  RSSI_VALID_LOW_RST  = 8'd18;
    localparam logic [7:0]  RSSI_VALID_HIGH_RST = 8'd120;
    localparam logic [7:0]  POWER_JAM_LEVEL_RST = 8'd30;

    // request codes
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    // detection codes
    localparam logic [1:0] DET_NONE  = 2'd0;
    localparam logic [1:0] DET_DUTY  = 2'd1;
    localparam logic [1:0] DET_POWER = 2'd2;

    // RSSI conversion and ring reset
    localparam logic signed [8:0] RSSI_OFFSET = 9'sd74;
    localparam logic [7:0]        RSSI_RST    = 8'd90;

    // percent scale for the duty compare
    localparam int PERCENT = 100;

    typedef struct packed {
        logic [6:0]  duty_threshold;
        logic [11:0] short_window_len;
        logic [11:0] long_window_len;
        logic [6:0]  run_needed;
        logic [7:0]  rssi_valid_low;
        logic [7:0]  rssi_valid_high;
        logic [7:0]  power_jam_level;
    } t_cfg;

    // window length as used: zero acts as one, above the counter max clamps
    function automatic logic [15:0] eff_len(input logic [11:0] len,
                                            input logic [15:0] cnt_max);
        logic [15:0] len16;
        len16 = {4'd0, len};
        if (len16 == 16'd0) begin
            eff_len = 16'd1;
        end else if (len16 > cnt_max) begin
            eff_len = cnt_max;
        end else begin
            eff_len = len16;
        end
    endfunction

endpackage

/* sv/rfjd_cfg.sv */
// ----------------------------------------------------------------------------
// rfjd_cfg: configuration register file
// Seven write-only registers loaded from the plain write port.
// ----------------------------------------------------------------------------
module rfjd_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rfjd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rfjd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output rfjd_pkg::t_cfg                 o_cfg
);

    rfjd_pkg::t_cfg r_cfg;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.duty_threshold   <= rfjd_pkg::DUTY_THRESHOLD_RST;
            r_cfg.short_window_len <= rfjd_pkg::SHORT_WINDOW_RST;
            r_cfg.long_window_len  <= rfjd_pkg::LONG_WINDOW_RST;
            r_cfg.run_needed       <= rfjd_pkg::RUN_NEEDED_RST;
            r_cfg.rssi_valid_low   <= rfjd_pkg::RSSI_VALID_LOW_RST;
            r_cfg.rssi_valid_high  <= rfjd_pkg::RSSI_VALID_HIGH_RST;
            r_cfg.power_jam_level  <= rfjd_pkg::POWER_JAM_LEVEL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rfjd_pkg::REG_DUTY_THRESHOLD:  r_cfg.duty_threshold   <= i_cfg_data[6:0];
                rfjd_pkg::REG_SHORT_WINDOW:    r_cfg.short_window_len <= i_cfg_data[11:0];
                rfjd_pkg::REG_LONG_WINDOW:     r_cfg.long_window_len  <= i_cfg_data[11:0];
                rfjd_pkg::REG_RUN_NEEDED:      r_cfg.run_needed       <= i_cfg_data[6:0];
                rfjd_pkg::REG_RSSI_VALID_LOW:  r_cfg.rssi_valid_low   <= i_cfg_data[7:0];
                rfjd_pkg::REG_RSSI_VALID_HIGH: r_cfg.rssi_valid_high  <= i_cfg_data[7:0];
                rfjd_pkg::REG_POWER_JAM_LEVEL: r_cfg.power_jam_level  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* sv/rfjd_duty.sv */
// ----------------------------------------------------------------------------
// rfjd_duty: duty-cycle screening and confirmation
// Counts samples and ones per window; a run of busy short windows opens a
// long confirmation window, which flags duty jamming when it is busy too.
// ----------------------------------------------------------------------------
module rfjd_duty #(
    parameter int COUNT_BITS = rfjd_pkg::COUNT_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rfjd_pkg::t_cfg i_cfg,
    input  logic           i_en,
    input  logic           i_data_bit,
    output logic           o_hit,
    output logic           o_phase_nxt
);

    localparam int          OW      = COUNT_BITS + 7;
    localparam int          LW      = COUNT_BITS + 8;
    localparam logic [15:0] CNT_MAX = 16'((1 << COUNT_BITS) - 1);

    logic                  r_phase;
    logic [COUNT_BITS-1:0] r_win_cnt;
    logic [OW-1:0]         r_ones100;
    logic [6:0]            r_run;

    logic                  n_phase;
    logic [COUNT_BITS-1:0] n_win_cnt;
    logic [OW-1:0]         n_ones100;
    logic [6:0]            n_run;

    logic [COUNT_BITS-1:0] len;
    logic [7:0]            thr_p1;
    logic [LW-1:0]         limit;
    logic [COUNT_BITS-1:0] win_inc;
    logic [OW-1:0]         ones_inc;
    logic [6:0]            need;
    logic [6:0]            run_inc;
    logic                  win_end;
    logic                  over;

    // window length of the current phase and the busy limit (thr+1)*len;
    // floor(100*ones/len) > thr is the same as 100*ones >= (thr+1)*len
    always_comb begin
        if (r_phase) begin
            len = COUNT_BITS'(rfjd_pkg::eff_len(i_cfg.long_window_len, CNT_MAX));
        end else begin
            len = COUNT_BITS'(rfjd_pkg::eff_len(i_cfg.short_window_len, CNT_MAX));
        end
        thr_p1 = {1'b0, i_cfg.duty_threshold} + 8'd1;
        limit  = LW'(thr_p1) * LW'(len);
    end

    // counters, one hundred per one bit so no multiply on the count
    always_comb begin
        win_inc  = r_win_cnt + COUNT_BITS'(1);
        ones_inc = r_ones100 + (i_data_bit ? OW'(rfjd_pkg::PERCENT) : OW'(0));
        win_end  = (win_inc >= len);
        over     = ({1'b0, ones_inc} >= limit);
        need     = (i_cfg.run_needed == 7'd0) ? 7'd1 : i_cfg.run_needed;
        run_inc  = r_run + 7'd1;
    end

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_win_cnt = win_inc;
        n_ones100 = ones_inc;
        n_run     = r_run;
        o_hit     = 1'b0;
        if (win_end) begin
            n_win_cnt = '0;
            n_ones100 = '0;
            if (!r_phase) begin
                if (over) begin
                    if (run_inc >= need) begin
                        n_phase = 1'b1;
                        n_run   = 7'd0;
                    end else begin
                        n_run   = run_inc;
                    end
                end else begin
                    n_run = 7'd0;
                end
            end else begin
                o_hit   = i_en && over;
                n_phase = 1'b0;
            end
        end
    end

    assign o_phase_nxt = i_en ? n_phase : r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= 1'b0;
            r_win_cnt <= '0;
            r_ones100 <= '0;
            r_run     <= 7'd0;
        end else if (i_en) begin
            r_phase   <= n_phase;
            r_win_cnt <= n_win_cnt;
            r_ones100 <= n_ones100;
            r_run     <= n_run;
        end
    end

endmodule

/* sv/rfjd_rssi.sv */
// ----------------------------------------------------------------------------
// rfjd_rssi: RSSI averaging ring and power check
// At each interval end the raw RSSI becomes a dB magnitude (old mean if out
// of range), enters the ring; the mean is compared with the power jam level.
// ----------------------------------------------------------------------------
module rfjd_rssi #(
    parameter int RSSI_DEPTH = rfjd_pkg::RSSI_DEPTH_DEF,
    parameter int COUNT_BITS = rfjd_pkg::COUNT_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rfjd_pkg::t_cfg i_cfg,
    input  logic           i_en,
    input  logic [7:0]     i_rssi_raw,
    output logic           o_hit,
    output logic [7:0]     o_avg_nxt
);

    localparam int          SLOT_W  = (RSSI_DEPTH > 1) ? $clog2(RSSI_DEPTH) : 1;
    localparam int          SUM_W   = $clog2(RSSI_DEPTH * 255 + 1);
    localparam int          K       = SUM_W + $clog2(RSSI_DEPTH);
    localparam int          MW      = K + 1;
    localparam int          PW      = SUM_W + MW;
    // reciprocal of the depth, exact floor for every sum in range
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << K) + 64'(RSSI_DEPTH) - 64'd1) / 64'(RSSI_DEPTH));
    localparam logic [SUM_W-1:0]  SUM_RST  = SUM_W'(RSSI_DEPTH * 90);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RSSI_DEPTH - 1);
    localparam logic [15:0]       CNT_MAX   = 16'((1 << COUNT_BITS) - 1);

    logic [7:0]            r_ring [RSSI_DEPTH];
    logic [SLOT_W-1:0]     r_slot;
    logic [SUM_W-1:0]      r_sum;
    logic [7:0]            r_avg;
    logic [COUNT_BITS-1:0] r_cnt;

    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  ivl_end;
    logic signed [8:0]     s_raw;
    logic signed [8:0]     s_half;
    logic signed [8:0]     s_mag;
    logic [7:0]            mag;
    logic [7:0]            val;
    logic [SUM_W:0]        sum_wide;
    logic [SUM_W-1:0]      n_sum;
    logic [PW-1:0]         prod;
    logic [7:0]            n_avg;
    logic [SLOT_W-1:0]     n_slot;

    // interval counter
    always_comb begin
        cnt_inc = r_cnt + COUNT_BITS'(1);
        ivl_end = (cnt_inc >= COUNT_BITS'(rfjd_pkg::eff_len(i_cfg.short_window_len,
                                                            CNT_MAX)));
    end

    // magnitude = 74 - s/2, halving truncates toward zero
    always_comb begin
        s_raw  = $signed({i_rssi_raw[7], i_rssi_raw});
        s_half = (s_raw + $signed({8'd0, i_rssi_raw[7]})) >>> 1;
        s_mag  = rfjd_pkg::RSSI_OFFSET - s_half;
        mag    = s_mag[7:0];
        if (mag > i_cfg.rssi_valid_high || mag < i_cfg.rssi_valid_low) begin
            val = r_avg;
        end else begin
            val = mag;
        end
    end

    // running ring sum and mean
    always_comb begin
        sum_wide = {1'b0, r_sum} + (SUM_W + 1)'(val) - (SUM_W + 1)'(r_ring[r_slot]);
        n_sum    = sum_wide[SUM_W-1:0];
        prod     = PW'(n_sum) * PW'(RECIP);
        n_avg    = prod[K+7:K];
        n_slot   = (r_slot == SLOT_LAST) ? '0 : r_slot + SLOT_W'(1);
    end

    assign o_hit     = i_en && ivl_end && (n_avg <= i_cfg.power_jam_level);
    assign o_avg_nxt = (i_en && ivl_end) ? n_avg : r_avg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RSSI_DEPTH; i++) begin
                r_ring[i] <= rfjd_pkg::RSSI_RST;
            end
            r_slot <= '0;
            r_sum  <= SUM_RST;
            r_avg  <= rfjd_pkg::RSSI_RST;
            r_cnt  <= '0;
        end else if (i_en) begin
            if (ivl_end) begin
                r_ring[r_slot] <= val;
                r_slot         <= n_slot;
                r_sum          <= n_sum;
                r_avg          <= n_avg;
                r_cnt          <= '0;
            end else begin
                r_cnt <= cnt_inc;
            end
        end
    end

endmodule

/* sv/rf_jamming_detector.sv */
// ----------------------------------------------------------------------------
// rf_jamming_detector: duty-cycle and low-power jamming detector
// Input register, single-pass update of the detector state, result register.
// ----------------------------------------------------------------------------
// Takes one word per clock while o_stall is low. A word goes to the input
// register, and its result word to the result register once the output is
// free; without output stalls throughput is one word per cycle, set by the
// single register-to-register update of the window counters and the RSSI ring
// sum. A sample tick (req_type 0) advances the windows; a clear (req_type 1)
// drops a pending detection and resumes. Once a code is reported, sample
// ticks are ignored until a clear. Users write registers through the plain
// write port only while no word is in flight; the block does not enforce it.
module rf_jamming_detector #(
    parameter int RSSI_DEPTH = rfjd_pkg::RSSI_DEPTH_DEF,
    parameter int COUNT_BITS = rfjd_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_req_type,
    input  logic                            i_data_bit,
    input  logic [7:0]                      i_rssi_raw,
    // output channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [1:0]                      o_detect_code,
    output logic                            o_confirm_phase,
    output logic [7:0]                      o_rssi_mean,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [rfjd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rfjd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    rfjd_pkg::t_cfg cfg;

    logic       r_in_vld;
    logic       r_req;
    logic       r_bit;
    logic [7:0] r_raw;
    logic [1:0] r_det;
    logic       r_out_vld;
    logic [1:0] r_out_det;
    logic       r_out_phase;
    logic [7:0] r_out_mean;

    logic [1:0] n_det;
    logic       out_free;
    logic       in_free;
    logic       fire;
    logic       upd_en;
    logic       duty_hit;
    logic       power_hit;
    logic       phase_nxt;
    logic [7:0] avg_nxt;

    // handshake
    assign out_free = !r_out_vld || !i_stall;
    assign fire     = r_in_vld && out_free;
    assign in_free  = !r_in_vld || out_free;
    assign o_stall  = !in_free;
    assign upd_en   = fire && (r_req == rfjd_pkg::REQ_SAMPLE)
                           && (r_det == rfjd_pkg::DET_NONE);

    rfjd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    rfjd_duty #(
        .COUNT_BITS (COUNT_BITS)
    ) u_duty (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_en        (upd_en),
        .i_data_bit  (r_bit),
        .o_hit       (duty_hit),
        .o_phase_nxt (phase_nxt)
    );

    rfjd_rssi #(
        .RSSI_DEPTH (RSSI_DEPTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_rssi (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_en       (upd_en),
        .i_rssi_raw (r_raw),
        .o_hit      (power_hit),
        .o_avg_nxt  (avg_nxt)
    );

    // detection code: a clear resets it, else the power check wins over the duty check
    always_comb begin
        if (r_req == rfjd_pkg::REQ_CLEAR) begin
            n_det = rfjd_pkg::DET_NONE;
        end else if (power_hit) begin
            n_det = rfjd_pkg::DET_POWER;
        end else if (duty_hit) begin
            n_det = rfjd_pkg::DET_DUTY;
        end else begin
            n_det = r_det;
        end
    end

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_free) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_valid) begin
            r_req <= i_req_type;
            r_bit <= i_data_bit;
            r_raw <= i_rssi_raw;
        end
    end

    // detection state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det <= rfjd_pkg::DET_NONE;
        end else if (fire) begin
            r_det <= n_det;
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_det   <= n_det;
            r_out_phase <= phase_nxt;
            r_out_mean  <= avg_nxt;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_detect_code   = r_out_det;
    assign o_confirm_phase = r_out_phase;
    assign o_rssi_mean     = r_out_mean;

endmodule
